// File: src/gjl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjl_pkg
// Shared widths, defaults, controller states and the command and status
// groups passed between the line justifier controller and datapath.
// ----------------------------------------------------------------------------
package gjl_pkg;

    localparam int MAX_LINE_WIDTH     = 64;
    localparam int MAX_WORDS_PER_LINE = 32;

    localparam int WL_W   = 7;
    localparam int CFG_W  = 7;
    localparam int WIL_W  = 5;
    localparam int SP_W   = 6;
    localparam int SP_MAX = (1 << SP_W) - 1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_EMIT_PRE,
        S_PLACE,
        S_EMIT_FIN
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic setup_close;
        logic close_left;
        logic emit;
        logic emit_ovl;
        logic run_end;
        logic place;
    } t_cmd;

    typedef struct packed {
        logic close_first;
        logic single;
        logic overlong;
        logic fin;
        logic div_busy;
        logic last_word;
        logic slot_free;
    } t_sts;

endpackage

// File: src/gjl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjl_in_if
// Input channel: one word length per transfer with a final word flag.
// ----------------------------------------------------------------------------
interface gjl_in_if;

    logic                     valid;
    logic                     ready;
    logic [gjl_pkg::WL_W-1:0] word_length;
    logic                     final_word;

    modport source (output valid, output word_length, output final_word, input ready);
    modport sink   (input valid, input word_length, input final_word, output ready);

endinterface

// File: src/gjl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjl_out_if
// Output channel: spacing result for one placed word.
// ----------------------------------------------------------------------------
interface gjl_out_if;

    logic                      valid;
    logic                      ready;
    logic [gjl_pkg::WIL_W-1:0] word_in_line;
    logic [gjl_pkg::SP_W-1:0]  spaces_after;
    logic                      line_end;
    logic                      overlong;
    logic                      last_of_run;

    modport source (
        output valid, output word_in_line, output spaces_after, output line_end,
        output overlong, output last_of_run, input ready
    );
    modport sink (
        input valid, input word_in_line, input spaces_after, input line_end,
        input overlong, input last_of_run, output ready
    );

endinterface

// File: src/gjl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjl_ctrl
// Sequencer for the line justifier: accepts a word, closes the buffered
// line when needed, places or flags the word and runs the final close.
// ----------------------------------------------------------------------------
module gjl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  gjl_pkg::t_sts i_sts,
    output gjl_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import gjl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.close_first) begin
                    o_cmd.setup_close = 1'b1;
                    o_cmd.close_left  = i_sts.single;
                    n_state           = S_DIV;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_EMIT_PRE;
                end
            end
            S_EMIT_PRE: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.run_end = i_sts.last_word && !i_sts.overlong && !i_sts.fin;
                    if (i_sts.last_word) begin
                        n_state = S_PLACE;
                    end
                end
            end
            S_PLACE: begin
                if (i_sts.overlong) begin
                    if (i_sts.slot_free) begin
                        o_cmd.emit_ovl = 1'b1;
                        o_cmd.run_end  = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.place = 1'b1;
                    if (i_sts.fin) begin
                        o_cmd.setup_close = 1'b1;
                        o_cmd.close_left  = 1'b1;
                        n_state           = S_EMIT_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT_FIN: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.run_end = i_sts.last_word;
                    if (i_sts.last_word) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/gjl_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gjl_dpath
// Line state, width register, slack divider and output register of the
// line justifier.
// ----------------------------------------------------------------------------
module gjl_dpath #(
    parameter int P_MAX_LINE_WIDTH = gjl_pkg::MAX_LINE_WIDTH,
    parameter int P_MAX_WORDS      = gjl_pkg::MAX_WORDS_PER_LINE
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [gjl_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic [gjl_pkg::WL_W-1:0]  i_word_length,
    input  logic                      i_final_word,
    input  gjl_pkg::t_cmd             i_cmd,
    output gjl_pkg::t_sts             o_sts,
    gjl_out_if.source                 o_out
);
    import gjl_pkg::*;

    localparam int LW_W    = $clog2(P_MAX_LINE_WIDTH + 1);
    localparam int CNT_W   = $clog2(P_MAX_WORDS + 1);
    localparam int M1_W    = (LW_W > CNT_W) ? LW_W : CNT_W;
    localparam int M2_W    = (M1_W > CFG_W) ? M1_W : CFG_W;
    localparam int WIDE_W  = M2_W + 2;
    localparam int DCNT_W  = $clog2(LW_W);

    logic [CFG_W-1:0]  r_line_width;
    logic [WL_W-1:0]   r_wl;
    logic              r_fin;
    logic [LW_W-1:0]   r_lw;
    logic [CNT_W-1:0]  r_count;
    logic [LW_W-1:0]   r_sum;
    logic [CNT_W-1:0]  r_idx;
    logic              r_left;
    logic [LW_W-1:0]   r_quo;
    logic [CNT_W-1:0]  r_part;
    logic [DCNT_W-1:0] r_div_cnt;
    logic              r_div_busy;

    logic              r_out_valid;
    logic [WIL_W-1:0]  r_wil;
    logic [SP_W-1:0]   r_sp;
    logic              r_end;
    logic              r_ovl;
    logic              r_lor;

    logic [WIDE_W-1:0] cfg_w;
    logic [WIDE_W-1:0] lw_eff_w;
    logic [WIDE_W-1:0] lw_w;
    logic [WIDE_W-1:0] sum_w;
    logic [WIDE_W-1:0] cnt_w;
    logic [WIDE_W-1:0] wl_w;
    logic [WIDE_W-1:0] idx_w;
    logic [WIDE_W-1:0] need;
    logic [WIDE_W-1:0] used;
    logic              fits;
    logic [WIDE_W-1:0] pad;
    logic [WIDE_W-1:0] slack;
    logic [WIDE_W-1:0] sp_val;
    logic [SP_W-1:0]   sp_sat;
    logic              not_last;
    logic [CNT_W-1:0]  gaps;
    logic [CNT_W:0]    part_sh;
    logic [CNT_W:0]    part_sub;
    logic              q_bit;
    logic              slot_free;

    always_comb begin
        cfg_w = WIDE_W'(r_line_width);
        if (cfg_w == '0) begin
            lw_eff_w = WIDE_W'(1);
        end else if (cfg_w > WIDE_W'(P_MAX_LINE_WIDTH)) begin
            lw_eff_w = WIDE_W'(P_MAX_LINE_WIDTH);
        end else begin
            lw_eff_w = cfg_w;
        end
    end

    assign lw_w     = WIDE_W'(r_lw);
    assign sum_w    = WIDE_W'(r_sum);
    assign cnt_w    = WIDE_W'(r_count);
    assign wl_w     = WIDE_W'(r_wl);
    assign idx_w    = WIDE_W'(r_idx);
    assign need     = sum_w + wl_w + cnt_w;
    assign used     = sum_w + cnt_w - WIDE_W'(1);
    assign fits     = (used <= lw_w);
    assign pad      = fits ? (lw_w - used) : '0;
    assign slack    = lw_w - sum_w;
    assign not_last = (idx_w < cnt_w - WIDE_W'(1));
    assign gaps     = r_count - CNT_W'(1);
    assign part_sh  = {r_part, r_quo[LW_W-1]};
    assign q_bit    = (part_sh >= {1'b0, gaps});
    assign part_sub = part_sh - {1'b0, gaps};

    // spacing for the word at the current index
    always_comb begin
        if (r_left) begin
            sp_val = not_last ? WIDE_W'(1) : pad;
        end else if (not_last) begin
            sp_val = WIDE_W'(r_quo)
                   + ((idx_w < WIDE_W'(r_part)) ? WIDE_W'(1) : WIDE_W'(0));
        end else begin
            sp_val = '0;
        end
        sp_sat = (sp_val > WIDE_W'(SP_MAX)) ? SP_W'(SP_MAX) : sp_val[SP_W-1:0];
    end

    assign slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        o_sts.close_first = (r_count != '0)
                          && ((cnt_w >= WIDE_W'(P_MAX_WORDS)) || (need > lw_w));
        o_sts.single      = (r_count == CNT_W'(1));
        o_sts.overlong    = (wl_w > lw_w);
        o_sts.fin         = r_fin;
        o_sts.div_busy    = r_div_busy;
        o_sts.last_word   = !not_last;
        o_sts.slot_free   = slot_free;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_count      <= '0;
            r_sum        <= '0;
            r_div_busy   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_line_width <= i_cfg_wdata;
            end
            if (i_cmd.emit && !not_last) begin
                r_count <= '0;
                r_sum   <= '0;
            end else if (i_cmd.place) begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + LW_W'(r_wl);
            end
            if (i_cmd.setup_close && !i_cmd.close_left && fits) begin
                r_div_busy <= 1'b1;
            end else if (r_div_busy && r_div_cnt == DCNT_W'(LW_W - 1)) begin
                r_div_busy <= 1'b0;
            end
            if (i_cmd.emit || i_cmd.emit_ovl) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_wl  <= i_word_length;
            r_fin <= i_final_word;
            r_lw  <= lw_eff_w[LW_W-1:0];
        end
        if (i_cmd.setup_close) begin
            r_idx     <= '0;
            r_left    <= i_cmd.close_left;
            r_div_cnt <= '0;
            r_part    <= '0;
            if (fits) begin
                r_quo <= slack[LW_W-1:0];
            end else begin
                r_quo <= LW_W'(1);
            end
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
            r_quo     <= {r_quo[LW_W-2:0], q_bit};
            r_part    <= q_bit ? part_sub[CNT_W-1:0] : part_sh[CNT_W-1:0];
        end else if (i_cmd.emit) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.emit) begin
            r_wil <= idx_w[WIL_W-1:0];
            r_sp  <= sp_sat;
            r_end <= !not_last;
            r_ovl <= 1'b0;
            r_lor <= i_cmd.run_end;
        end else if (i_cmd.emit_ovl) begin
            r_wil <= '0;
            r_sp  <= '0;
            r_end <= 1'b1;
            r_ovl <= 1'b1;
            r_lor <= i_cmd.run_end;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.word_in_line = r_wil;
    assign o_out.spaces_after = r_sp;
    assign o_out.line_end     = r_end;
    assign o_out.overlong     = r_ovl;
    assign o_out.last_of_run  = r_lor;

endmodule

// File: src/greedy_line_justifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_line_justifier_unit
// Greedy full justification of a word stream, one spacing word per input.
//
// i_in carries word lengths with a final word flag; o_out returns, for each
// word of a closed line, its position and the spaces that follow it.
// i_cfg_we / i_cfg_wdata set the line width; write only while idle.
// Words are taken one at a time. A word that only joins the buffered line
// holds i_in.ready low while it is decided and placed, and gives no output.
// A word that closes a line first runs the shift-subtract divider, one step
// per bit of the line width, for a justified line that fits, then emits one
// output per word of the line through the output register. An overlong
// word gives one flagged output; a final word also closes the final line
// and emits one output per word of it.
// Reset empties the line buffer, drops any pending output and sets the
// line width to 64. A stalled receiver holds the output register and the
// sequencer waits; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module greedy_line_justifier_unit #(
    parameter int P_MAX_LINE_WIDTH = gjl_pkg::MAX_LINE_WIDTH,
    parameter int P_MAX_WORDS      = gjl_pkg::MAX_WORDS_PER_LINE
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [gjl_pkg::CFG_W-1:0] i_cfg_wdata,
    gjl_in_if.sink                    i_in,
    gjl_out_if.source                 o_out
);
    import gjl_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_in.ready = in_ready;

    gjl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    gjl_dpath #(
        .P_MAX_LINE_WIDTH (P_MAX_LINE_WIDTH),
        .P_MAX_WORDS      (P_MAX_WORDS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_word_length (i_in.word_length),
        .i_final_word  (i_in.final_word),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out         (o_out)
    );

endmodule
